/* hw/rtl/ps2mct_pkg.sv */
package ps2mct_pkg;

  // configuration register indexes
  localparam logic REG_DISPLAY_WIDTH  = 1'b0;
  localparam logic REG_DISPLAY_HEIGHT = 1'b1;

  // protocol bytes and masks
  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] SYNC_MASK = 8'hC8;
  localparam logic [7:0] SYNC_BITS = 8'h08;

  localparam logic [11:0] DISPLAY_WIDTH_RST  = 12'd320;
  localparam logic [11:0] DISPLAY_HEIGHT_RST = 12'd200;
  localparam logic [11:0] POS_RST            = 12'd100;

  // decoded packet, handed from the packet tracker to the cursor logic
  typedef struct packed {
    logic        done;
    logic [2:0]  buttons;
    logic [8:0]  delta_x;
    logic [9:0]  delta_y;
  } pkt_t;

endpackage

/* hw/rtl/ps2mct_packet.sv */
module ps2mct_packet (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  output ps2mct_pkg::pkt_t   pkt
);
  import ps2mct_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_ACK = 2'd0,
    PH_FIRST    = 2'd1,
    PH_SECOND   = 2'd2,
    PH_THIRD    = 2'd3
  } phase_t;

  phase_t     phase;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [8:0] dy_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT_ACK;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (step) begin
      unique case (phase)
        PH_WAIT_ACK: begin
          if (data_byte == ACK_BYTE) phase <= PH_FIRST;
        end
        PH_FIRST: begin
          if ((data_byte & SYNC_MASK) == SYNC_BITS) begin
            first_byte <= data_byte;
            phase      <= PH_SECOND;
          end
        end
        PH_SECOND: begin
          second_byte <= data_byte;
          phase       <= PH_THIRD;
        end
        PH_THIRD: begin
          phase <= PH_FIRST;
        end
        default: phase <= PH_WAIT_ACK;
      endcase
    end
  end

  // third byte completes the packet; sign bits come from the first byte
  assign dy_raw      = {first_byte[5], data_byte};
  assign pkt.done    = (phase == PH_THIRD);
  assign pkt.buttons = first_byte[2:0];
  assign pkt.delta_x = {first_byte[4], second_byte};
  assign pkt.delta_y = 10'(-$signed({dy_raw[8], dy_raw}));

endmodule

/* hw/rtl/ps2mct_axis_clamp.sv */
module ps2mct_axis_clamp #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic [11:0]       pos,
  input  logic signed [9:0] delta,
  input  logic [11:0]       extent,
  output logic [11:0]       pos_next
);

  logic signed [13:0] limit;
  logic signed [13:0] sum;

  always_comb begin
    limit = $signed({2'b00, extent}) - 14'(CURSOR_SIZE);
    if (limit < 0) limit = '0;
    sum = $signed({2'b00, pos}) + 14'(delta);
    priority if (sum < 0) begin
      pos_next = '0;
    end else if (sum > limit) begin
      pos_next = limit[11:0];
    end else begin
      pos_next = sum[11:0];
    end
  end

endmodule

/* hw/rtl/ps2_mouse_packet_cursor_tracker.sv */
// channel | dir | beat contents
// s_axis  | in  | tdata[7:0] data_byte
// m_axis  | out | tdata buttons, delta_x, delta_y, cursor_x, cursor_y
// cfg     | in  | cfg_wr_en, cfg_addr (0 width, 1 height), cfg_wdata[11:0]
//
// one byte per cycle unless a held result stalls; bytes pass the input
// register, and completed packets go out on m_axis from the result register
// rst is synchronous: waits for the acknowledge byte, cursor at 100,100
// a held result only stalls bytes that would complete a packet; other bytes
// keep flowing, and while such a byte waits s_tready follows m_tready
// combinationally in the same cycle
module ps2_mouse_packet_cursor_tracker #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [33:22] cursor_x,
  // [45:34] cursor_y, [47:46] zero
  output logic [47:0] m_tdata,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import ps2mct_pkg::*;

  logic [11:0] display_width;
  logic [11:0] display_height;

  // input register
  logic       in_v;
  logic [7:0] in_byte;
  logic       advance;

  pkt_t        pkt;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [11:0] pos_x_next;
  logic [11:0] pos_y_next;

  // result register
  logic        out_v;
  logic [2:0]  out_buttons;
  logic [8:0]  out_dx;
  logic [9:0]  out_dy;

  // a byte moves on unless it completes a packet while a result is stuck
  assign advance  = in_v && (!pkt.done || !out_v || m_tready);
  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= DISPLAY_WIDTH_RST;
      display_height <= DISPLAY_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DISPLAY_WIDTH:  display_width  <= cfg_wdata;
        REG_DISPLAY_HEIGHT: display_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  ps2mct_packet u_packet (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .pkt       (pkt)
  );

  ps2mct_axis_clamp #(.CURSOR_SIZE(CURSOR_SIZE)) u_clamp_x (
    .pos      (pos_x),
    .delta    ({pkt.delta_x[8], pkt.delta_x}),
    .extent   (display_width),
    .pos_next (pos_x_next)
  );

  ps2mct_axis_clamp #(.CURSOR_SIZE(CURSOR_SIZE)) u_clamp_y (
    .pos      (pos_y),
    .delta    (pkt.delta_y),
    .extent   (display_height),
    .pos_next (pos_y_next)
  );

  // cursor position and result register load together on a completed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= POS_RST;
      pos_y <= POS_RST;
      out_v <= 1'b0;
    end else begin
      if (advance && pkt.done) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pkt.done) begin
      out_buttons <= pkt.buttons;
      out_dx      <= pkt.delta_x;
      out_dy      <= pkt.delta_y;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {2'b00, pos_y, pos_x, out_dy, out_dx, out_buttons};

  // a result appears only from a byte held in the input register
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(in_v))
    else $error("result without a byte in the input register");

  // a completed packet always lands in the result register
  a_packet_lands: assert property (@(posedge clk) disable iff (rst)
    advance && pkt.done |=> out_v)
    else $error("completed packet lost");

  // a blocked byte stays put in the input register
  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_v && !advance |=> in_v && $stable(in_byte))
    else $error("blocked byte changed");

  // cursor only moves when a packet completes
  a_cursor_moves_on_packet: assert property (@(posedge clk) disable iff (rst)
    !(advance && pkt.done) |=> $stable(pos_x) && $stable(pos_y))
    else $error("cursor moved without a packet");

endmodule

/* test/ps2mct_checker.sv */
`timescale 1ns / 1ps

module ps2mct_checker #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);
  import ps2mct_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_ACK,
    WANT_FIRST,
    WANT_SECOND,
    WANT_THIRD
  } rx_phase_t;

  typedef struct packed {
    logic [2:0]  buttons;
    logic [8:0]  delta_x;
    logic [9:0]  delta_y;
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;
  } motion_t;

  rx_phase_t   rx_phase;
  logic [7:0]  head_byte;
  logic [7:0]  x_byte;
  logic [11:0] cur_x;
  logic [11:0] cur_y;
  logic [11:0] disp_w;
  logic [11:0] disp_h;
  motion_t     motion_q[$];

  // keeps the cursor inside 0 .. extent - CURSOR_SIZE, floor of the bound is 0
  function automatic logic [11:0] clamp_cursor(logic [11:0] pos, int delta,
                                               logic [11:0] extent);
    int bound;
    int p;
    bound = int'(extent) - CURSOR_SIZE;
    p = int'(pos) + delta;
    if (bound < 0) bound = 0;
    if (p < 0) p = 0;
    if (p > bound) p = bound;
    return p[11:0];
  endfunction

  task automatic track_byte(input logic [7:0] b);
    int      dx;
    int      dy;
    motion_t m;
    case (rx_phase)
      AWAIT_ACK: begin
        if (b == ACK_BYTE) rx_phase = WANT_FIRST;
      end
      WANT_FIRST: begin
        if ((b & SYNC_MASK) == SYNC_BITS) begin
          head_byte = b;
          rx_phase = WANT_SECOND;
        end
      end
      WANT_SECOND: begin
        x_byte = b;
        rx_phase = WANT_THIRD;
      end
      default: begin
        rx_phase = WANT_FIRST;
        // sign bits of both motions sit in the head byte
        dx = int'(x_byte) - (head_byte[4] ? 256 : 0);
        dy = -(int'(b) - (head_byte[5] ? 256 : 0));
        cur_x = clamp_cursor(cur_x, dx, disp_w);
        cur_y = clamp_cursor(cur_y, dy, disp_h);
        m.buttons  = head_byte[2:0];
        m.delta_x  = dx[8:0];
        m.delta_y  = dy[9:0];
        m.cursor_x = cur_x;
        m.cursor_y = cur_y;
        motion_q.push_back(m);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    motion_t want;
    if (rst) begin
      rx_phase   = AWAIT_ACK;
      head_byte  = '0;
      x_byte     = '0;
      cur_x      = POS_RST;
      cur_y      = POS_RST;
      disp_w     = DISPLAY_WIDTH_RST;
      disp_h     = DISPLAY_HEIGHT_RST;
      mismatches = 0;
      motion_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_DISPLAY_WIDTH) disp_w = cfg_wdata;
        else disp_h = cfg_wdata;
      end
      // a result never belongs to a byte taken at the same edge
      if (m_tvalid && m_tready) begin
        if (motion_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected, tdata %h", $realtime, m_tdata);
        end else begin
          want = motion_q.pop_front();
          check_field("buttons", want.buttons, m_tdata[2:0]);
          check_field("delta_x", want.delta_x, m_tdata[11:3]);
          check_field("delta_y", want.delta_y, m_tdata[21:12]);
          check_field("cursor_x", want.cursor_x, m_tdata[33:22]);
          check_field("cursor_y", want.cursor_y, m_tdata[45:34]);
          check_field("pad", 0, m_tdata[47:46]);
        end
      end
      if (s_tvalid && s_tready) track_byte(s_tdata);
    end
    pending <= motion_q.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ps2mct_pkg::*;

  localparam int CURSOR = 16;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        cfg_wr_en;
  logic        cfg_addr;
  logic [11:0] cfg_wdata;

  int mismatches;
  int pending;
  // chance in percent that the byte source or the result sink idles in a cycle
  int tx_idle_pct;
  int rx_idle_pct;

  ps2_mouse_packet_cursor_tracker #(
    .CURSOR_SIZE(CURSOR)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // predicts from the accepted beats and compares every result beat
  ps2mct_checker #(
    .CURSOR_SIZE(CURSOR)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1ms;
    $display("** ps2_mouse_packet_cursor_tracker: FAILED **");
    $finish;
  end

  // result sink, stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // one byte beat, with random idle cycles ahead of it; valid stays high
  // after the handshake so back-to-back beats need no extra toggling
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(head);
    send_byte(dx);
    send_byte(dy);
  endtask

  // source goes quiet until every result is back, then lets a byte that
  // makes no result drain out of the input register
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_display(input logic [11:0] w, input logic [11:0] h);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_DISPLAY_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= REG_DISPLAY_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        tx_idle_pct = 26;
        rx_idle_pct = 51;
      end
      1: begin
        tx_idle_pct = 51;
        rx_idle_pct = 26;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  // mostly well-formed packets with random content, some stray bytes
  task automatic mouse_traffic(input int n_packets);
    int         pick;
    logic [7:0] head;
    logic [7:0] dx;
    logic [7:0] dy;
    for (int i = 0; i < n_packets; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // any byte; at a packet start most fail the sync test
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 11) begin
        send_byte(ACK_BYTE);
      end
      head = (8'($urandom_range(0, 255)) & ~SYNC_MASK) | SYNC_BITS;
      if ($urandom_range(0, 1)) begin
        dx = 8'($urandom_range(0, 255));
        dy = 8'($urandom_range(0, 255));
      end else begin
        // small motions so the cursor also travels between the bounds
        dx = head[4] ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
        dy = head[5] ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
      end
      send_packet(head, dx, dy);
    end
  endtask

  logic [11:0] widths[6];
  logic [11:0] heights[6];

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_DISPLAY_WIDTH;
    cfg_wdata <= '0;
    set_idling(0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bytes ahead of the acknowledge are dropped, a sync-looking one too
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h08);
    send_byte(ACK_BYTE);
    // first bytes that fail the sync test, a second acknowledge among them
    send_byte(ACK_BYTE);
    send_byte(8'hC8);
    send_byte(8'h48);
    send_byte(8'h80);
    send_byte(8'h00);
    // all buttons, largest positive dx, zero dy
    send_packet(8'h0F, 8'hFF, 8'h00);
    // both signs set with zero bytes: dx -256, dy turns into +256
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'h38, 8'hFF, 8'hFF);
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'h0A, 8'h01, 8'h01);
    drain();

    // full screen first so the cursor can wander far, then a shrink that
    // leaves it outside until the next packet, then displays below cursor size
    widths  = '{12'd4095, 12'd16, 12'd15, 12'd0, 12'd320, 12'd320};
    heights = '{12'd4095, 12'd16, 12'd0, 12'd4095, 12'd200, 12'd200};
    widths[4]  = 12'($urandom_range(16, 4095));
    heights[4] = 12'($urandom_range(16, 4095));
    for (int ph = 0; ph < 6; ph++) begin
      set_display(widths[ph], heights[ph]);
      set_idling(ph % 3);
      mouse_traffic(22);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("** ps2_mouse_packet_cursor_tracker: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_cursor_tracker: FAILED **");
    end
    $finish;
  end

endmodule

/* ps2_mouse_packet_cursor_tracker.f */
hw/rtl/ps2mct_pkg.sv
hw/rtl/ps2mct_packet.sv
hw/rtl/ps2mct_axis_clamp.sv
hw/rtl/ps2_mouse_packet_cursor_tracker.sv
test/ps2mct_checker.sv
test/testbench.sv
